// ===== hdl/srsq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sequence resequencer package
// Shared types, codes and constants for the resequencer and its checker.
// ----------------------------------------------------------------------------
package srsq_pkg;

  localparam int unsigned WINDOW_DEF  = 1024;
  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned IN_DATA_W   = 40;
  localparam int unsigned OUT_DATA_W  = 56;
  localparam int unsigned ENTRY_W     = 21;
  localparam logic [5:0]  GIVEUP_RST  = 6'd63;

  typedef logic [1:0] act_t;
  localparam act_t ACT_DISPATCH = 2'd0;
  localparam act_t ACT_FRAGMENT = 2'd1;
  localparam act_t ACT_CLOSING  = 2'd2;
  localparam act_t ACT_SESSION  = 2'd3;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_GIVEUP   = 2'd0;
  localparam cfg_idx_t CFG_ZONE     = 2'd1;
  localparam cfg_idx_t CFG_TRACKING = 2'd2;

  typedef logic [1:0] sess_t;
  localparam sess_t SESS_OFF     = 2'd0;
  localparam sess_t SESS_TRACK   = 2'd1;
  localparam sess_t SESS_LATCHED = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ANCH, S_LOOK, S_RELST, S_SKIP, S_REL, S_FIN
  } state_t;

  typedef struct packed {
    logic        req_type;
    logic        has_seq;
    logic [15:0] seq_num;
    logic        seq_start;
    logic        close_hi;
    logic        close_lo;
    logic        has_ack_seq;
    logic        is_fragment;
    logic        crc_ok;
    logic        has_opcode;
    logic [15:0] handle;
  } pkt_t;

  typedef struct packed {
    logic        valid;
    logic        close_lo;
    logic        close_hi;
    logic        fragment;
    logic        ack;
    logic [15:0] handle;
  } entry_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [15:0] seq;
    act_t        act;
    logic [15:0] expected;
    logic [5:0]  count;
  } res_t;

  typedef struct packed {
    logic vld;
    act_t act;
  } cls_t;

  function automatic cls_t classify(input logic ack, input logic frag, input logic chi,
                                    input logic clo, input logic op, input logic zone);
    cls_t c;
    c.vld = 1'b1;
    c.act = ACT_DISPATCH;
    if (!ack && !frag && !chi) begin
      c.vld = 1'b0;
    end else if (chi && clo && zone) begin
      c.act = ACT_CLOSING;
    end else if (frag) begin
      c.act = ACT_FRAGMENT;
    end else begin
      c.vld = op;
    end
    return c;
  endfunction

endpackage

// ===== hdl/srsq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module srsq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/sequence_resequencer.sv =====
// ----------------------------------------------------------------------------
// Sequence resequencer
// Puts sequenced packet descriptors back in order through a slot memory.
// ----------------------------------------------------------------------------
// Requests enter on the in_ stream and released descriptors leave on the
// out_ stream; one request may release none or up to 64 descriptors, the
// final one flagged by out_tlast. Registers are to be written through cfg_
// only while the block is idle, which the block itself does not enforce;
// the cfg_ channel is always ready. A sequenced request steps through the
// slot memory: one step per stored entry released, one for the skip check
// and one per missing number skipped; every step is one access to the
// single slot memory.
// After reset, and after a stream reset request, a clearing pass writes every
// slot of the memory, during which in_tready is low.
// When the receiver stalls, the last result waits in the output register and
// a further result waits in a holding register; the walk halts until room
// appears. The next request is taken while the final result still waits.
// ----------------------------------------------------------------------------
module sequence_resequencer
  import srsq_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // has_seq, seq_num, seq_start, close_hi, close_lo, has_ack_seq,
  // is_fragment, crc_ok, has_opcode, handle
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_handle, out_seq, expected_seq, stored_count, zero padding
  output logic [OUT_DATA_W-1:0] out_tdata,
  // action
  output logic [1:0]            out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_addr,
  input  logic [5:0]            cfg_data
);

  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam logic [16:0] WIN_L  = 17'(WINDOW);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
  localparam logic [6:0]  MAX_L  = 7'(MAX_RESULTS);

  state_t      state_r, state_nxt;
  pkt_t        pkt_r, pkt_nxt;
  logic [15:0] exp_r, exp_nxt;
  logic        anch_r, anch_nxt;
  sess_t       sess_r, sess_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [5:0]  thr_r, thr_nxt;
  logic        zone_r, zone_nxt;
  logic [6:0]  n_r, n_nxt;
  logic [SLOT_W-1:0] k_r, k_nxt;
  logic [SLOT_W-1:0] clr_r, clr_nxt;
  logic        pend_v_r, pend_v_nxt;
  res_t        pend_r, pend_nxt;
  logic        out_v_r, out_v_nxt;
  res_t        out_r, out_nxt;
  logic        out_last_r, out_last_nxt;

  logic              ram_we, ram_re;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  entry_t            ram_wdata, rd;

  logic        out_free, push_ok, prod, go;
  res_t        res;
  cls_t        cl;
  logic [15:0] e1, d;
  logic [5:0]  cnt_d;
  logic        latch;

  srsq_ram #(.WIDTH(ENTRY_W), .DEPTH(WINDOW)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rd)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_r.count, out_r.expected, out_r.seq, out_r.handle};
  assign out_tuser  = out_r.act;
  assign out_tlast  = out_last_r;
  assign out_free   = !out_v_r || out_tready;
  assign push_ok    = !pend_v_r || out_free;

  always_comb begin
    state_nxt    = state_r;
    pkt_nxt      = pkt_r;
    exp_nxt      = exp_r;
    anch_nxt     = anch_r;
    sess_nxt     = sess_r;
    cnt_nxt      = cnt_r;
    thr_nxt      = thr_r;
    zone_nxt     = zone_r;
    n_nxt        = n_r;
    k_nxt        = k_r;
    clr_nxt      = clr_r;
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    out_v_nxt    = out_v_r && !out_tready;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    ram_we       = 1'b0;
    ram_waddr    = exp_r[SLOT_W-1:0];
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = exp_r[SLOT_W-1:0];
    prod         = 1'b0;
    res          = '0;
    e1           = exp_r + 16'd1;
    d            = pkt_r.seq_num - exp_r;
    cnt_d        = (cnt_r != 6'd0) ? cnt_r - 6'd1 : cnt_r;
    latch        = 1'b0;
    cl           = '0;

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == SLOT_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          pkt_nxt.req_type    = in_tuser;
          pkt_nxt.has_seq     = in_tdata[0];
          pkt_nxt.seq_num     = in_tdata[16:1];
          pkt_nxt.seq_start   = in_tdata[17];
          pkt_nxt.close_hi    = in_tdata[18];
          pkt_nxt.close_lo    = in_tdata[19];
          pkt_nxt.has_ack_seq = in_tdata[20];
          pkt_nxt.is_fragment = in_tdata[21];
          pkt_nxt.crc_ok      = in_tdata[22];
          pkt_nxt.has_opcode  = in_tdata[23];
          pkt_nxt.handle      = in_tdata[39:24];
          n_nxt   = '0;
          if (in_tuser) begin
            exp_nxt   = '0;
            anch_nxt  = 1'b0;
            cnt_nxt   = '0;
            clr_nxt   = '0;
            state_nxt = S_CLEAR;
          end else begin
            state_nxt = S_ANCH;
          end
        end
      end
      S_ANCH: begin
        if (!pkt_r.has_seq) begin
          prod = pkt_r.has_opcode;
          res  = '{pkt_r.handle, 16'd0, ACT_DISPATCH, exp_r, cnt_r};
        end else begin
          latch = pkt_r.seq_start && !pkt_r.close_lo && (sess_r < SESS_LATCHED) &&
                  zone_r && (sess_r != SESS_OFF);
          prod  = latch;
          res   = '{pkt_r.handle, pkt_r.seq_num, ACT_SESSION, pkt_r.seq_num, cnt_r};
        end
      end
      S_LOOK: begin
        if (exp_r == pkt_r.seq_num) begin
          cl   = classify(pkt_r.has_ack_seq, pkt_r.is_fragment, pkt_r.close_hi,
                          pkt_r.close_lo, pkt_r.has_opcode, zone_r);
          prod = cl.vld;
          res  = '{pkt_r.handle, pkt_r.seq_num, cl.act, e1, cnt_r};
        end
      end
      S_REL: begin
        cl   = classify(rd.ack, rd.fragment, rd.close_hi, rd.close_lo, 1'b1, zone_r);
        prod = rd.valid && cl.vld;
        res  = '{rd.handle, exp_r, cl.act, e1, cnt_d};
      end
      default: begin
      end
    endcase

    go = !(prod && (n_r < MAX_L) && !push_ok);

    unique case (state_r)
      S_ANCH: begin
        if (go) begin
          if (!pkt_r.has_seq) begin
            state_nxt = S_FIN;
          end else begin
            if (pkt_r.seq_start && !pkt_r.close_lo && (sess_r < SESS_LATCHED)) begin
              exp_nxt  = pkt_r.seq_num;
              anch_nxt = 1'b1;
              if (latch) begin
                sess_nxt = SESS_LATCHED;
              end
            end else if (!anch_r && (sess_r == SESS_OFF) && !pkt_r.close_hi &&
                         !pkt_r.close_lo && zone_r) begin
              exp_nxt  = pkt_r.seq_num;
              anch_nxt = 1'b1;
            end
            ram_re    = 1'b1;
            ram_raddr = pkt_r.seq_num[SLOT_W-1:0];
            state_nxt = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        if (exp_r == pkt_r.seq_num) begin
          if (go) begin
            exp_nxt = e1;
            if (cl.vld && (cl.act == ACT_CLOSING)) begin
              if (sess_r != SESS_OFF) begin
                sess_nxt = SESS_TRACK;
              end
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_RELST;
            end
          end
        end else begin
          if ((d != 16'd0) && ({1'b0, d} < WIN_L)) begin
            ram_waddr = pkt_r.seq_num[SLOT_W-1:0];
            ram_wdata = '{1'b1, pkt_r.close_lo, pkt_r.close_hi, pkt_r.is_fragment,
                          pkt_r.has_ack_seq, pkt_r.handle};
            if (!rd.valid) begin
              ram_we = 1'b1;
              if (cnt_r != 6'd63) begin
                cnt_nxt = cnt_r + 6'd1;
              end
            end else begin
              ram_we = pkt_r.crc_ok;
            end
          end
          state_nxt = S_RELST;
        end
      end
      S_RELST: begin
        if (cnt_r == 6'd0) begin
          state_nxt = S_FIN;
        end else begin
          ram_re    = 1'b1;
          k_nxt     = '0;
          state_nxt = (cnt_r >= thr_r) ? S_SKIP : S_REL;
        end
      end
      S_SKIP: begin
        if (rd.valid) begin
          state_nxt = S_REL;
        end else begin
          exp_nxt = e1;
          k_nxt   = k_r + 1'b1;
          if (k_r == SLOT_LAST) begin
            state_nxt = S_FIN;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = e1[SLOT_W-1:0];
          end
        end
      end
      S_REL: begin
        if (!rd.valid) begin
          state_nxt = S_FIN;
        end else if (go) begin
          ram_we  = 1'b1;
          exp_nxt = e1;
          cnt_nxt = cnt_d;
          if (cl.vld && (cl.act == ACT_CLOSING)) begin
            if (sess_r != SESS_OFF) begin
              sess_nxt = SESS_TRACK;
            end
            state_nxt = S_FIN;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = e1[SLOT_W-1:0];
          end
        end
      end
      S_FIN: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_v_nxt    = 1'b1;
          out_nxt      = pend_r;
          out_last_nxt = 1'b1;
          pend_v_nxt   = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
      end
    endcase

    if (prod && go && (n_r < MAX_L)) begin
      n_nxt = n_r + 7'd1;
      if (pend_v_r) begin
        out_v_nxt    = 1'b1;
        out_nxt      = pend_r;
        out_last_nxt = 1'b0;
      end
      pend_v_nxt = 1'b1;
      pend_nxt   = res;
    end

    if (cfg_valid) begin
      unique case (cfg_addr)
        CFG_GIVEUP:   thr_nxt  = cfg_data;
        CFG_ZONE:     zone_nxt = cfg_data[0];
        CFG_TRACKING: sess_nxt = {1'b0, cfg_data[0]};
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      exp_r    <= '0;
      anch_r   <= 1'b0;
      sess_r   <= SESS_OFF;
      cnt_r    <= '0;
      thr_r    <= GIVEUP_RST;
      zone_r   <= 1'b0;
      n_r      <= '0;
      k_r      <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      exp_r    <= exp_nxt;
      anch_r   <= anch_nxt;
      sess_r   <= sess_nxt;
      cnt_r    <= cnt_nxt;
      thr_r    <= thr_nxt;
      zone_r   <= zone_nxt;
      n_r      <= n_nxt;
      k_r      <= k_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pkt_r      <= pkt_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// ===== hdl/srsq_checker.sv =====
// ----------------------------------------------------------------------------
// Sequence resequencer port checker
// Watches the top-level ports over time; bound to every instance.
// ----------------------------------------------------------------------------
module srsq_checker
  import srsq_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("activity straight after reset");

  a_stream_reset: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("request taken during clearing pass");

  a_latch_anchor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ACT_SESSION) |-> out_tdata[47:32] == out_tdata[31:16])
    else $error("session latch not anchored on its own number");

endmodule

bind sequence_resequencer srsq_checker u_srsq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sequence resequencer testbench
// Drives packet requests, stream resets and register writes into the
// resequencer, predicts every released descriptor in a scoreboard and checks
// each result field by field, with random idling on both streams.
// ----------------------------------------------------------------------------
import srsq_pkg::*;

typedef struct {
  logic [15:0] handle;
  logic [15:0] seq;
  act_t        act;
  logic [15:0] next_seq;
  logic [5:0]  count;
  logic        last;
} release_t;

class reorder_scoreboard;
  logic [19:0] slot_word [1024];
  bit          slot_used [1024];
  logic [15:0] next_seq;
  bit          anchored;
  sess_t       sess;
  logic [5:0]  held;
  logic [5:0]  giveup;
  bit          zone;
  release_t    pending [$];
  int          errors;
  int          n_req;
  int          n_rel;
  int          n_out;

  function new();
    foreach (slot_used[i]) slot_used[i] = 0;
    next_seq = 0;
    anchored = 0;
    sess = SESS_OFF;
    held = 0;
    giveup = GIVEUP_RST;
    zone = 0;
  endfunction

  function void write_reg(cfg_idx_t idx, logic [5:0] val);
    case (idx)
      CFG_GIVEUP: giveup = val;
      CFG_ZONE: zone = val[0];
      CFG_TRACKING: sess = val[0] ? SESS_TRACK : SESS_OFF;
      default: ;
    endcase
  endfunction

  function int kind_of(logic ack, logic frag, logic chi, logic clo, logic op);
    if (!ack && !frag && !chi) return -1;
    if (chi && clo && zone) return int'(ACT_CLOSING);
    if (frag) return int'(ACT_FRAGMENT);
    return op ? int'(ACT_DISPATCH) : -1;
  endfunction

  function void emit(ref int n, input logic [15:0] h, input logic [15:0] s, input int a);
    release_t r;
    if (n >= MAX_RESULTS) return;
    r.handle = h;
    r.seq = s;
    r.act = act_t'(a);
    r.next_seq = next_seq;
    r.count = held;
    r.last = 0;
    pending.push_back(r);
    n++;
  endfunction

  function void note_request(pkt_t p);
    int n;
    int a;
    bit done;
    logic [15:0] d;
    logic [9:0] s;
    logic [19:0] e;
    logic [15:0] eseq;
    n = 0;
    done = 0;
    n_req++;
    if (p.req_type) begin
      foreach (slot_used[i]) slot_used[i] = 0;
      held = 0;
      next_seq = 0;
      anchored = 0;
      return;
    end
    if (!p.has_seq) begin
      if (p.has_opcode) emit(n, p.handle, 16'd0, int'(ACT_DISPATCH));
    end else begin
      if (p.seq_start && !p.close_lo && sess < SESS_LATCHED) begin
        next_seq = p.seq_num;
        anchored = 1;
        if (zone && sess != SESS_OFF) begin
          sess = SESS_LATCHED;
          emit(n, p.handle, p.seq_num, int'(ACT_SESSION));
        end
      end else if (!anchored && sess == SESS_OFF && !p.close_hi && !p.close_lo && zone) begin
        next_seq = p.seq_num;
        anchored = 1;
      end
      if (next_seq == p.seq_num) begin
        next_seq = p.seq_num + 16'd1;
        a = kind_of(p.has_ack_seq, p.is_fragment, p.close_hi, p.close_lo, p.has_opcode);
        if (a == int'(ACT_CLOSING)) begin
          if (sess != SESS_OFF) sess = SESS_TRACK;
          done = 1;
        end
        if (a >= 0) emit(n, p.handle, p.seq_num, a);
      end else begin
        d = p.seq_num - next_seq;
        if (d >= 1 && d < 1024) begin
          s = p.seq_num[9:0];
          if (!slot_used[s]) begin
            slot_word[s] = {p.close_lo, p.close_hi, p.is_fragment, p.has_ack_seq, p.handle};
            slot_used[s] = 1;
            if (held < 63) held++;
          end else if (p.crc_ok) begin
            slot_word[s] = {p.close_lo, p.close_hi, p.is_fragment, p.has_ack_seq, p.handle};
          end
        end
      end
      if (!done && held != 0) begin
        if (held >= giveup) begin
          for (int k = 0; k < 1024 && !slot_used[next_seq[9:0]]; k++) next_seq++;
        end
        for (int k = 0; k < 1024; k++) begin
          s = next_seq[9:0];
          if (!slot_used[s]) break;
          e = slot_word[s];
          eseq = next_seq;
          slot_used[s] = 0;
          if (held > 0) held--;
          next_seq++;
          a = kind_of(e[16], e[17], e[18], e[19], 1'b1);
          if (a >= 0) emit(n, e[15:0], eseq, a);
          if (a == int'(ACT_CLOSING)) begin
            if (sess != SESS_OFF) sess = SESS_TRACK;
            break;
          end
        end
      end
    end
    if (n > 0) pending[$].last = 1;
    n_rel += n;
  endfunction

  function void check_release(logic [15:0] h, logic [15:0] s, act_t a, logic [15:0] nx,
                              logic [5:0] c, logic l);
    release_t w;
    n_out++;
    if (pending.size() == 0) begin
      $error("unexpected release: handle %h seq %h", h, s);
      errors++;
      return;
    end
    w = pending.pop_front();
    if (h !== w.handle) begin
      $error("out_handle: expected %h, actual %h", w.handle, h); errors++;
    end
    if (s !== w.seq) begin
      $error("out_seq: expected %h, actual %h", w.seq, s); errors++;
    end
    if (a !== w.act) begin
      $error("action: expected %0d, actual %0d", w.act, a); errors++;
    end
    if (nx !== w.next_seq) begin
      $error("expected_seq: expected %h, actual %h", w.next_seq, nx); errors++;
    end
    if (c !== w.count) begin
      $error("stored_count: expected %0d, actual %0d", w.count, c); errors++;
    end
    if (l !== w.last) begin
      $error("last: expected %0d, actual %0d", w.last, l); errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int DRAIN = 2400;
  localparam int LIMIT = 1000000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [1:0]            cfg_addr;
  logic [5:0]            cfg_data;

  reorder_scoreboard sb;
  bit calm;
  int cycles;

  sequence_resequencer dut (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  initial begin
    sb = new();
    calm = 0;
    cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_addr = CFG_GIVEUP;
    cfg_data = '0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("sequence_resequencer test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.check_release(out_tdata[15:0], out_tdata[31:16], out_tuser, out_tdata[47:32],
                         out_tdata[53:48], out_tlast);
      out_tready <= calm || ($urandom_range(99) >= 17);
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [5:0] val);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send(pkt_t p);
    if (!calm && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= p.req_type;
    in_tdata <= {p.handle, p.has_opcode, p.crc_ok, p.is_fragment, p.has_ack_seq,
                 p.close_lo, p.close_hi, p.seq_start, p.seq_num, p.has_seq};
    do @(posedge clk); while (!in_tready);
    sb.note_request(p);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic pkt_t mk(logic [15:0] s, logic st, logic chi, logic clo, logic ack,
                              logic frag, logic crc, logic op, logic [15:0] h);
    pkt_t p;
    p.req_type = 0; p.has_seq = 1; p.seq_num = s; p.seq_start = st;
    p.close_hi = chi; p.close_lo = clo; p.has_ack_seq = ack; p.is_fragment = frag;
    p.crc_ok = crc; p.has_opcode = op; p.handle = h;
    return p;
  endfunction

  function automatic pkt_t random_req();
    pkt_t p;
    int m;
    logic [63:0] rnd;
    rnd = {$urandom, $urandom};
    p = rnd[$bits(pkt_t)-1:0];
    p.req_type = 0;
    m = $urandom_range(99);
    if (m < 4) begin
      p.req_type = 1;
    end else if (m < 12) begin
      p.has_seq = 0;
    end else if (m >= 20) begin
      p.has_seq = 1;
      if ($urandom_range(9) == 0)
        p.seq_num = sb.next_seq - 16'($urandom_range(1, 6));
      else
        p.seq_num = sb.next_seq + 16'($urandom_range(0, 7));
      p.seq_start = ($urandom_range(19) == 0);
      p.has_ack_seq = ($urandom_range(9) < 7);
      p.is_fragment = ($urandom_range(9) < 2);
      p.close_hi = ($urandom_range(9) < 1);
      p.close_lo = ($urandom_range(9) < 1);
      p.crc_ok = ($urandom_range(9) < 8);
      p.has_opcode = ($urandom_range(9) < 9);
    end
    return p;
  endfunction

  task automatic run_random(int n);
    repeat (n) send(random_req());
  endtask

  initial begin
    pkt_t p;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(CFG_ZONE, 6'd1);
    write_reg(CFG_TRACKING, 6'd1);
    write_reg(CFG_GIVEUP, 6'd63);

    p = mk(16'h1234, 0, 0, 0, 1, 0, 1, 1, 16'h0000); p.has_seq = 0; send(p);
    p.has_opcode = 0; p.handle = 16'hffff; send(p);
    send(mk(16'hfffe, 1, 0, 0, 1, 0, 1, 1, 16'hffff));
    send(mk(16'h0001, 0, 0, 0, 1, 1, 1, 1, 16'h1111));
    send(mk(16'h0001, 0, 0, 0, 1, 0, 0, 1, 16'h2222));
    send(mk(16'h0001, 0, 0, 0, 1, 0, 1, 0, 16'h3333));
    send(mk(16'hffff, 0, 0, 0, 0, 0, 1, 1, 16'h4444));
    send(mk(16'h0000, 0, 0, 0, 1, 0, 1, 0, 16'h5555));
    send(mk(16'hfe00, 0, 0, 0, 1, 0, 1, 1, 16'h6666));
    send(mk(16'h0003, 0, 1, 1, 1, 0, 1, 1, 16'h7777));
    send(mk(16'h0002, 0, 0, 0, 1, 0, 1, 1, 16'h8888));
    send(mk(16'h0005, 0, 0, 0, 1, 1, 1, 1, 16'h9999));
    send(mk(16'h0006, 0, 1, 0, 0, 0, 1, 1, 16'haaaa));
    send(mk(16'h0004, 0, 1, 1, 0, 0, 1, 0, 16'hbbbb));
    send(mk(16'h0005, 0, 0, 0, 1, 0, 1, 1, 16'hcccc));
    send(mk(16'h0010, 1, 0, 0, 1, 0, 1, 1, 16'hdddd));
    send(mk(16'h0020, 1, 0, 1, 1, 0, 1, 1, 16'heeee));
    send(mk(16'h0011, 0, 0, 0, 1, 0, 1, 1, 16'h0f0f));
    p.req_type = 1; send(p);
    send(mk(16'h0000, 1, 0, 1, 1, 0, 1, 1, 16'h0000));
    send(mk(16'h0000, 0, 0, 0, 1, 0, 1, 1, 16'h0001));
    settle();

    write_reg(CFG_GIVEUP, 6'd1);
    send(mk(16'h0003, 0, 0, 0, 1, 0, 1, 1, 16'h0303));
    send(mk(16'h0009, 0, 0, 0, 1, 1, 1, 1, 16'h0909));
    run_random(35);
    settle();

    calm = 1;
    write_reg(CFG_ZONE, 6'd0);
    write_reg(CFG_TRACKING, 6'd0);
    write_reg(CFG_GIVEUP, 6'd4);
    run_random(45);
    settle();

    calm = 0;
    write_reg(CFG_ZONE, 6'd1);
    write_reg(CFG_GIVEUP, 6'd63);
    run_random(45);
    settle();

    write_reg(CFG_TRACKING, 6'd1);
    write_reg(CFG_GIVEUP, 6'd2);
    run_random(60);
    settle();

    $display("Covered %0d requests and %0d releases over five register settings,",
             sb.n_req, sb.n_out);
    $display("including stream resets, session latch, closing and gap skipping.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("sequence_resequencer test passed");
    end else begin
      $display("sequence_resequencer test failed");
    end
    $finish;
  end
endmodule
